### rtl/urlrb_pkg.sv
// ============================================================================
// urlrb_pkg
// Shared types and constants of the serial receive ring buffer: operation
// codes, controller states, output selection and controller/datapath links.
// ============================================================================
package urlrb_pkg;

    // Stream field widths
    localparam int unsigned S_TDATA_W = 8;   // rx_byte
    localparam int unsigned S_TUSER_W = 2;   // operation
    localparam int unsigned M_TDATA_W = 16;  // data_byte, lines_pending
    localparam int unsigned M_TUSER_W = 2;   // empty_res, terminator
    localparam int unsigned BYTE_W    = 8;

    // Configuration port
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_HANDLER = 2'd0;

    // Special byte values
    localparam logic [BYTE_W-1:0] BYTE_NUL = 8'd0;
    localparam logic [BYTE_W-1:0] BYTE_LF  = 8'd10;
    localparam logic [BYTE_W-1:0] BYTE_CR  = 8'd13;

    // Operation codes carried in the input tuser
    typedef enum logic [1:0] {
        OP_PUSH       = 2'd0,
        OP_READ_BYTE  = 2'd1,
        OP_READ_LINE  = 2'd2,
        OP_LINE_EVENT = 2'd3
    } t_op;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,  // waiting for an input beat
        ST_BYTE  = 2'd1,  // single byte read, data arriving from the ring
        ST_LCHK  = 2'd2,  // line read, check and emit the fetched byte
        ST_LTERM = 2'd3   // line read, emit the terminator
    } t_state;

    // What the output register is loaded with
    typedef enum logic [1:0] {
        SEL_STATUS = 2'd0,
        SEL_EMPTY  = 2'd1,
        SEL_MEM    = 2'd2,
        SEL_TERM   = 2'd3
    } t_out_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic     push;      // store the input byte (with drop and full rules)
        logic     read_adv;  // advance read index and fetch that entry
        logic     flush;     // empty the ring
        logic     line_dec;  // take one line off the count
        logic     out_load;  // load the output register
        t_out_sel out_sel;
        logic     out_last;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic ring_empty;
        logic lines_zero;
        logic stop_byte;     // fetched byte ends a line
        logic out_free;      // output register can take a beat this cycle
    } t_dp_sts;

endpackage

### rtl/urlrb_cfg.sv
// ============================================================================
// urlrb_cfg
// APB register file: holds the handler_present flag.
// ============================================================================
module urlrb_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic [urlrb_pkg::CFG_ADDR_W-1:0]    i_paddr,
    input  logic [urlrb_pkg::CFG_DATA_W-1:0]    i_pwdata,
    output logic [urlrb_pkg::CFG_DATA_W-1:0]    o_prdata,
    output logic                                o_pready,
    output logic                                o_handler
);

    logic r_handler;

    assign o_pready  = 1'b1;
    assign o_handler = r_handler;

    // Write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_handler <= 1'b0;
        end else if (i_psel && i_penable && i_pwrite
                     && (i_paddr == urlrb_pkg::CFG_ADDR_HANDLER)) begin
            r_handler <= i_pwdata[0];
        end
    end

    // Read back
    always_comb begin
        unique case (i_paddr)
            urlrb_pkg::CFG_ADDR_HANDLER: begin
                o_prdata = {{(urlrb_pkg::CFG_DATA_W-1){1'b0}}, r_handler};
            end
            default: begin
                o_prdata = '0;
            end
        endcase
    end

endmodule

### rtl/urlrb_dp.sv
// ============================================================================
// urlrb_dp
// Datapath: ring memory, write and read indices, line count and the output
// register of the result stream.
// ============================================================================
module urlrb_dp #(
    parameter int unsigned RING_DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  urlrb_pkg::t_dp_cmd                  i_cmd,
    output urlrb_pkg::t_dp_sts                  o_sts,
    input  logic [urlrb_pkg::BYTE_W-1:0]        i_rx_byte,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [urlrb_pkg::M_TDATA_W-1:0]     o_m_tdata,
    output logic [urlrb_pkg::M_TUSER_W-1:0]     o_m_tuser,
    output logic                                o_m_tlast
);

    localparam int unsigned IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

    logic [urlrb_pkg::BYTE_W-1:0] r_ring [RING_DEPTH];
    logic [urlrb_pkg::BYTE_W-1:0] r_rd_data;

    logic [IDX_W-1:0]             r_write_index, n_write_index;
    logic [IDX_W-1:0]             r_read_index,  n_read_index;
    logic [urlrb_pkg::BYTE_W-1:0] r_line_count,  n_line_count;

    logic [IDX_W-1:0]             w_next_write;
    logic [IDX_W-1:0]             w_next_read;
    logic                         w_full;
    logic                         w_store;

    logic                         r_out_valid;
    logic [urlrb_pkg::BYTE_W-1:0] r_out_data;
    logic [urlrb_pkg::BYTE_W-1:0] r_out_lines;
    logic                         r_out_empty;
    logic                         r_out_term;
    logic                         r_out_last;

    function automatic logic [IDX_W-1:0] f_next_slot(input logic [IDX_W-1:0] idx);
        return (idx == IDX_LAST) ? '0 : idx + IDX_W'(1);
    endfunction

    assign w_next_write = f_next_slot(r_write_index);
    assign w_next_read  = f_next_slot(r_read_index);
    assign w_full       = (w_next_write == r_read_index);
    assign w_store      = i_cmd.push && !w_full
                          && (i_rx_byte != urlrb_pkg::BYTE_NUL)
                          && (i_rx_byte != urlrb_pkg::BYTE_LF);

    // Next indices and line count
    always_comb begin
        n_write_index = r_write_index;
        n_read_index  = r_read_index;
        n_line_count  = r_line_count;
        if (i_cmd.push && w_full) begin
            n_write_index = r_read_index;
        end else if (w_store) begin
            n_write_index = w_next_write;
            if (i_rx_byte == urlrb_pkg::BYTE_CR) begin
                n_line_count = r_line_count + 8'd1;
            end
        end
        if (i_cmd.flush) begin
            n_write_index = r_read_index;
        end
        if (i_cmd.read_adv) begin
            n_read_index = w_next_read;
        end
        if (i_cmd.line_dec) begin
            n_line_count = r_line_count - 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_index <= '0;
            r_read_index  <= '0;
            r_line_count  <= '0;
        end else begin
            r_write_index <= n_write_index;
            r_read_index  <= n_read_index;
            r_line_count  <= n_line_count;
        end
    end

    // Ring memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_ring[w_next_write] <= i_rx_byte;
        end
        if (i_cmd.read_adv) begin
            r_rd_data <= r_ring[w_next_read];
        end
    end

    // Output register: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register: payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_lines <= n_line_count;
            r_out_last  <= i_cmd.out_last;
            case (i_cmd.out_sel)
                urlrb_pkg::SEL_EMPTY: begin
                    r_out_data  <= '0;
                    r_out_empty <= 1'b1;
                    r_out_term  <= 1'b0;
                end
                urlrb_pkg::SEL_MEM: begin
                    r_out_data  <= r_rd_data;
                    r_out_empty <= 1'b0;
                    r_out_term  <= 1'b0;
                end
                urlrb_pkg::SEL_TERM: begin
                    r_out_data  <= '0;
                    r_out_empty <= 1'b0;
                    r_out_term  <= 1'b1;
                end
                default: begin
                    r_out_data  <= '0;
                    r_out_empty <= 1'b0;
                    r_out_term  <= 1'b0;
                end
            endcase
        end
    end

    // Status towards the controller
    assign o_sts.ring_empty = (r_write_index == r_read_index);
    assign o_sts.lines_zero = (r_line_count == '0);
    assign o_sts.stop_byte  = (r_rd_data == urlrb_pkg::BYTE_NUL)
                              || (r_rd_data == urlrb_pkg::BYTE_CR)
                              || r_rd_data[urlrb_pkg::BYTE_W-1];
    assign o_sts.out_free   = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_lines, r_out_data};
    assign o_m_tuser  = {r_out_term, r_out_empty};
    assign o_m_tlast  = r_out_last;

endmodule

### rtl/urlrb_ctrl.sv
// ============================================================================
// urlrb_ctrl
// Controller: decodes each input beat and sequences byte and line reads
// through the datapath.
// ============================================================================
module urlrb_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [urlrb_pkg::S_TUSER_W-1:0]     i_op,
    input  logic                                i_handler,
    input  urlrb_pkg::t_dp_sts                  i_sts,
    output urlrb_pkg::t_dp_cmd                  o_cmd
);

    urlrb_pkg::t_state r_state, n_state;
    urlrb_pkg::t_op    w_op;
    logic              w_accept;
    logic              w_line_go;   // accepted beat starts a line read

    assign w_op       = urlrb_pkg::t_op'(i_op);
    assign o_s_tready = (r_state == urlrb_pkg::ST_IDLE) && i_sts.out_free;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_line_go  = !i_sts.lines_zero
                        && ((w_op == urlrb_pkg::OP_READ_LINE) || i_handler);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= urlrb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            urlrb_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (w_op) inside
                        urlrb_pkg::OP_READ_BYTE: begin
                            if (!i_sts.ring_empty) begin
                                n_state = urlrb_pkg::ST_BYTE;
                            end
                        end
                        urlrb_pkg::OP_READ_LINE, urlrb_pkg::OP_LINE_EVENT: begin
                            if (w_line_go) begin
                                n_state = i_sts.ring_empty ? urlrb_pkg::ST_LTERM
                                                           : urlrb_pkg::ST_LCHK;
                            end
                        end
                        default: begin
                            n_state = urlrb_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            urlrb_pkg::ST_BYTE: begin
                if (i_sts.out_free) begin
                    n_state = urlrb_pkg::ST_IDLE;
                end
            end
            urlrb_pkg::ST_LCHK: begin
                if (i_sts.stop_byte) begin
                    n_state = urlrb_pkg::ST_LTERM;
                end else if (i_sts.out_free && i_sts.ring_empty) begin
                    n_state = urlrb_pkg::ST_LTERM;
                end
            end
            urlrb_pkg::ST_LTERM: begin
                if (i_sts.out_free) begin
                    n_state = urlrb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = urlrb_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.out_sel  = urlrb_pkg::SEL_STATUS;
        unique case (r_state)
            urlrb_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (w_op)
                        urlrb_pkg::OP_PUSH: begin
                            o_cmd.push     = 1'b1;
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_last = 1'b1;
                        end
                        urlrb_pkg::OP_READ_BYTE: begin
                            if (i_sts.ring_empty) begin
                                o_cmd.out_load = 1'b1;
                                o_cmd.out_sel  = urlrb_pkg::SEL_EMPTY;
                                o_cmd.out_last = 1'b1;
                            end else begin
                                o_cmd.read_adv = 1'b1;
                            end
                        end
                        default: begin
                            if (w_line_go) begin
                                o_cmd.line_dec = 1'b1;
                                o_cmd.read_adv = !i_sts.ring_empty;
                            end else begin
                                // no lines, or a line event without a handler
                                o_cmd.flush    = !i_sts.lines_zero;
                                o_cmd.out_load = 1'b1;
                                o_cmd.out_last = 1'b1;
                            end
                        end
                    endcase
                end
            end
            urlrb_pkg::ST_BYTE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = urlrb_pkg::SEL_MEM;
                    o_cmd.out_last = 1'b1;
                end
            end
            urlrb_pkg::ST_LCHK: begin
                // emit the byte and fetch the next while the ring holds more
                if (!i_sts.stop_byte && i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = urlrb_pkg::SEL_MEM;
                    o_cmd.read_adv = !i_sts.ring_empty;
                end
            end
            urlrb_pkg::ST_LTERM: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = urlrb_pkg::SEL_TERM;
                    o_cmd.out_last = 1'b1;
                end
            end
            default: begin
                o_cmd.out_load = 1'b0;
            end
        endcase
    end

endmodule

### rtl/uart_rx_line_ring_buffer.sv
// ============================================================================
// uart_rx_line_ring_buffer
// Receive ring buffer for serial bytes with line assembly and line counting.
// ============================================================================
// One input beat at a time is worked on. A push, a status result and a read
// of an empty ring load the output register on acceptance; a byte read goes
// through ST_BYTE, since the ring memory has a registered read port. A line
// read goes through ST_LCHK for each byte taken from the ring (the closing CR
// or high byte included), then ST_LTERM for the terminator, as long as the
// result side keeps up. The ring memory is not cleared after reset; entries
// that were never written are never read. Results pass through one output
// register, so a new input beat is taken while the last result is accepted.
module uart_rx_line_ring_buffer #(
    parameter int unsigned RING_DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [urlrb_pkg::S_TDATA_W-1:0]     i_s_tdata,  // [7:0] rx_byte
    input  logic [urlrb_pkg::S_TUSER_W-1:0]     i_s_tuser,  // [1:0] operation
    // result stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [urlrb_pkg::M_TDATA_W-1:0]     o_m_tdata,  // [7:0] data_byte,
                                                            // [15:8] lines_pending
    output logic [urlrb_pkg::M_TUSER_W-1:0]     o_m_tuser,  // [0] empty_res,
                                                            // [1] terminator
    output logic                                o_m_tlast,
    // configuration
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic [urlrb_pkg::CFG_ADDR_W-1:0]    i_paddr,
    input  logic [urlrb_pkg::CFG_DATA_W-1:0]    i_pwdata,
    output logic [urlrb_pkg::CFG_DATA_W-1:0]    o_prdata,
    output logic                                o_pready
);

    urlrb_pkg::t_dp_cmd w_cmd;
    urlrb_pkg::t_dp_sts w_sts;
    logic               w_handler;

    urlrb_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_handler (w_handler)
    );

    urlrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_op       (i_s_tuser),
        .i_handler  (w_handler),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    urlrb_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_rx_byte  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

### rtl/urlrb_checker.sv
// ============================================================================
// urlrb_checker
// Port-level checks of the ring buffer's result stream, bound to the top.
// ============================================================================
module urlrb_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    input  logic                                i_s_tready,
    input  logic [urlrb_pkg::S_TUSER_W-1:0]     i_s_tuser,
    input  logic                                i_m_tvalid,
    input  logic                                i_m_tready,
    input  logic [urlrb_pkg::M_TDATA_W-1:0]     i_m_tdata,
    input  logic [urlrb_pkg::M_TUSER_W-1:0]     i_m_tuser,
    input  logic                                i_m_tlast
);

    // Hold a stalled result beat
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata)
                                      && $stable(i_m_tuser) && $stable(i_m_tlast))
        else $error("result beat changed while stalled");

    // A push gives its single status beat in the next cycle
    a_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready && (i_s_tuser == urlrb_pkg::OP_PUSH)
        |=> i_m_tvalid && i_m_tlast && (i_m_tuser == '0)
            && (i_m_tdata[urlrb_pkg::BYTE_W-1:0] == '0))
        else $error("push did not give a status beat");

    // A terminator carries a zero byte and ends the item
    a_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser[1]
        |-> i_m_tlast && !i_m_tuser[0] && (i_m_tdata[urlrb_pkg::BYTE_W-1:0] == '0))
        else $error("malformed terminator beat");

    // An empty flag carries a zero byte and ends the item
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser[0]
        |-> i_m_tlast && (i_m_tdata[urlrb_pkg::BYTE_W-1:0] == '0))
        else $error("malformed empty beat");

endmodule

bind uart_rx_line_ring_buffer urlrb_checker u_urlrb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser),
    .i_m_tlast  (o_m_tlast)
);
